@@ rtl/pixel_blend_unit_macros.svh @@
// assertion macros for the pixel blend unit
`ifndef PIXEL_BLEND_UNIT_MACROS_SVH
`define PIXEL_BLEND_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, off during reset
`define PBU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel blend unit assertion failed");
// next-cycle implication on clk, off during reset
`define PBU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel blend unit assertion failed");
`else
`define PBU_ASSERT_IMP(lbl, ante, cons)
`define PBU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/pbu_pkg.sv @@
package pbu_pkg;

	typedef enum logic [1:0] {
		MODE_COPY  = 2'd0,
		MODE_BLEND = 2'd1,
		MODE_ADD   = 2'd2,
		MODE_SUB   = 2'd3
	} blend_mode_t;

	localparam logic REG_BLEND_MODE   = 1'b0;
	localparam logic REG_GLOBAL_ALPHA = 1'b1;

	localparam logic [7:0]  CHAN_MAX    = 8'hFF;
	localparam logic [7:0]  GA_RESET    = 8'hFF;
	localparam logic [15:0] FULL_WEIGHT = 16'd65025;
	// ceil(2^40 / 65025); exact floor division for dividends below 2^40 / 63749
	localparam logic [24:0] RECIP_M     = 25'd16909061;

	typedef struct packed {
		blend_mode_t mode;
		logic [7:0]  global_alpha;
	} cfg_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} lane_ctl_t;

endpackage

@@ rtl/pbu_cfg_regs.sv @@
module pbu_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	output pbu_pkg::cfg_t cfg
);
	import pbu_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_COPY;
			cfg_q.global_alpha <= GA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_MODE:   cfg_q.mode <= blend_mode_t'(cfg_data[1:0]);
				REG_GLOBAL_ALPHA: cfg_q.global_alpha <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/pbu_chan_lane.sv @@
module pbu_chan_lane (
	input  logic              clk,
	input  pbu_pkg::lane_ctl_t ctl,
	input  logic [15:0]       w_s1,
	input  logic [7:0]        src_s1,
	input  logic [7:0]        dst_s1,
	input  logic              blend_s1,
	output logic [7:0]        q_s4
);
	import pbu_pkg::*;

	logic [23:0] ps_s2;
	logic [23:0] pd_s2;
	logic        blend_s2;
	logic [23:0] x_s3;
	logic [24:0] sum;
	logic [48:0] prod;

	// weighted source and weighted destination
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			ps_s2    <= 24'(w_s1) * 24'(src_s1);
			pd_s2    <= 24'(FULL_WEIGHT - w_s1) * 24'(dst_s1);
			blend_s2 <= blend_s1;
		end
	end

	// dividend stays below 65025 * 256
	assign sum = {1'b0, ps_s2} + (blend_s2 ? {1'b0, pd_s2} : 25'd0);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3)
			x_s3 <= sum[23:0];
	end

	// floor(x / 65025) by reciprocal multiply
	assign prod = 49'(x_s3) * 49'(RECIP_M);

	always_ff @(posedge clk) begin
		if (ctl.ld_s4)
			q_s4 <= prod[47:40];
	end

endmodule

@@ rtl/pixel_blend_unit.sv @@
// pixel_blend_unit: ARGB8888 copy / alpha blend / add / subtract
// an accepted word passes stages s1 to s5 in order; out_valid is the s5 valid bit
// throughput: one word per cycle while out_stall is low, through the five-stage pipeline
// a stage loads when it is empty or the stage after it moves on
// reset clears all valid bits, blend_mode to copy and global_alpha to 255
`include "pixel_blend_unit_macros.svh"

module pixel_blend_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_pixel,
	output logic        write_enable
);
	import pbu_pkg::*;

	cfg_t        cfg;
	lane_ctl_t   ctl;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;
	logic [31:0] src_s1, src_s2, src_s3, src_s4;
	logic [31:0] dst_s1, dst_s2, dst_s3, dst_s4;
	blend_mode_t mode_s1, mode_s2, mode_s3, mode_s4;
	logic        gaz_s1, gaz_s2, gaz_s3, gaz_s4;
	logic [15:0] w_s1;
	logic [7:0]  q_s4 [3];
	logic [7:0]  res_chan [3];
	logic [31:0] pix_s5;
	logic        we_s5;
	logic [31:0] pix_next;
	logic        we_next;

	pbu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// bubble-collapsing load enables
	assign ready_s5 = !valid_s5 || !out_stall;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	assign ctl.ld_s2 = ready_s2;
	assign ctl.ld_s3 = ready_s3;
	assign ctl.ld_s4 = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: source weight global_alpha * src_alpha
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			src_s1  <= src_pixel;
			dst_s1  <= dst_pixel;
			mode_s1 <= cfg.mode;
			gaz_s1  <= (cfg.global_alpha == 8'd0);
			w_s1    <= 16'(cfg.global_alpha) * 16'(src_pixel[31:24]);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
			mode_s2 <= mode_s1;
			gaz_s2  <= gaz_s1;
		end
		if (ready_s3) begin
			src_s3  <= src_s2;
			dst_s3  <= dst_s2;
			mode_s3 <= mode_s2;
			gaz_s3  <= gaz_s2;
		end
		if (ready_s4) begin
			src_s4  <= src_s3;
			dst_s4  <= dst_s3;
			mode_s4 <= mode_s3;
			gaz_s4  <= gaz_s3;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [8:0] add_sum;

		pbu_chan_lane u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.w_s1     (w_s1),
			.src_s1   (src_s1[8*i +: 8]),
			.dst_s1   (dst_s1[8*i +: 8]),
			.blend_s1 (mode_s1 == MODE_BLEND),
			.q_s4     (q_s4[i])
		);

		assign add_sum = {1'b0, q_s4[i]} + {1'b0, dst_s4[8*i +: 8]};

		always_comb begin
			case (mode_s4)
				MODE_ADD: res_chan[i] = add_sum[8] ? CHAN_MAX : add_sum[7:0];
				MODE_SUB: res_chan[i] = (q_s4[i] > dst_s4[8*i +: 8]) ? 8'd0
					: dst_s4[8*i +: 8] - q_s4[i];
				default:  res_chan[i] = q_s4[i];
			endcase
		end
	end

	always_comb begin
		if (mode_s4 == MODE_COPY) begin
			pix_next = src_s4;
			we_next  = 1'b1;
		end else if (gaz_s4) begin
			pix_next = dst_s4;
			we_next  = 1'b0;
		end else begin
			pix_next = {CHAN_MAX, res_chan[2], res_chan[1], res_chan[0]};
			we_next  = 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (ready_s5) begin
			pix_s5 <= pix_next;
			we_s5  <= we_next;
		end
	end

	assign out_valid    = valid_s5;
	assign out_pixel    = pix_s5;
	assign write_enable = we_s5;

	`PBU_ASSERT_IMP(a_stall_only_when_full, in_stall, valid_s1)
	`PBU_ASSERT_NXT(a_s1_holds, valid_s1 && !ready_s2, valid_s1 && $stable(src_s1))
	`PBU_ASSERT_IMP(a_stall_needs_full_pipe, !ready_s1,
		valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall)

endmodule

@@ bench/tb_pixel_blend_unit.sv @@
`timescale 1ns / 100ps

module tb_pixel_blend_unit;
	import pbu_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_WORDS = 1500;
	localparam int N_DIRECTED = 23;

	typedef struct packed {
		logic [31:0] pix;
		logic        we;
	} blend_result_t;

	typedef struct packed {
		logic [7:0]  mode_data;
		logic [7:0]  ga;
		logic [31:0] src;
		logic [31:0] dst;
		logic        known;
		logic [31:0] exp_pix;
		logic        exp_we;
	} blend_row_t;

	// typed-in results only where they follow at a glance; the rest go through the predictor
	localparam blend_row_t DIRECTED [N_DIRECTED] = '{
		// copy with the register values left from reset
		'{8'h00, 8'hFF, 32'h12345678, 32'hFFFFFFFF, 1'b1, 32'h12345678, 1'b1},
		'{8'h00, 8'hFF, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1},
		'{8'h00, 8'hFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1},
		// copy ignores a zero global alpha
		'{8'h00, 8'h00, 32'h80A0B0C0, 32'h01020304, 1'b1, 32'h80A0B0C0, 1'b1},
		// alpha blend
		'{8'h01, 8'hFF, 32'hFF102030, 32'h00ABCDEF, 1'b1, 32'hFF102030, 1'b1},
		'{8'h01, 8'hFF, 32'h00FFFFFF, 32'h11223344, 1'b1, 32'hFF223344, 1'b1},
		'{8'h01, 8'h00, 32'hFFFFFFFF, 32'h5A6B7C8D, 1'b1, 32'h5A6B7C8D, 1'b0},
		'{8'h01, 8'h80, 32'h80FF0080, 32'h00FF8000, 1'b0, 32'h0, 1'b0},
		'{8'h01, 8'h01, 32'h01FFFFFF, 32'h00000000, 1'b1, 32'hFF000000, 1'b1},
		'{8'h01, 8'hC8, 32'h7F405060, 32'hC0A0B0E0, 1'b0, 32'h0, 1'b0},
		// additive, saturating at full scale
		'{8'h02, 8'hFF, 32'hFF808080, 32'h00808080, 1'b1, 32'hFFFFFFFF, 1'b1},
		'{8'h02, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1},
		'{8'h02, 8'hFF, 32'h00FFFFFF, 32'h00010203, 1'b1, 32'hFF010203, 1'b1},
		'{8'h02, 8'h00, 32'hFF808080, 32'hA1B2C3D4, 1'b1, 32'hA1B2C3D4, 1'b0},
		'{8'h02, 8'h64, 32'h9C204060, 32'h10E0F0A0, 1'b0, 32'h0, 1'b0},
		// subtractive, clamping at zero
		'{8'h03, 8'hFF, 32'hFFFFFFFF, 32'h12345678, 1'b1, 32'hFF000000, 1'b1},
		'{8'h03, 8'hFF, 32'hFF010101, 32'h00000000, 1'b1, 32'hFF000000, 1'b1},
		'{8'h03, 8'hFF, 32'h00FFFFFF, 32'h00ABCDEF, 1'b1, 32'hFFABCDEF, 1'b1},
		'{8'h03, 8'h00, 32'hFFFFFFFF, 32'h76543210, 1'b1, 32'h76543210, 1'b0},
		'{8'h03, 8'h4D, 32'hE0406080, 32'h3050A0FF, 1'b0, 32'h0, 1'b0},
		// mode register keeps only its low bits
		'{8'hFE, 8'hFF, 32'hFF010203, 32'h00102030, 1'b1, 32'hFF112233, 1'b1},
		'{8'h7D, 8'hFF, 32'hFFABCDEF, 32'h00000000, 1'b1, 32'hFFABCDEF, 1'b1},
		'{8'hFC, 8'hFF, 32'hDEADBEEF, 32'h00000000, 1'b1, 32'hDEADBEEF, 1'b1}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_BLEND_MODE;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] src_pixel = 32'h0;
	logic [31:0] dst_pixel = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_pixel;
	logic        write_enable;

	blend_result_t pending_pixels [$];
	blend_mode_t   cur_mode = MODE_COPY;
	logic [7:0]    cur_mode_data = 8'h00;
	logic [7:0]    cur_ga = GA_RESET;
	int            mode_words [4] = '{0, 0, 0, 0};
	int            n_random = 0;
	int            n_checked = 0;
	int            n_suppressed = 0;
	int            n_errors = 0;
	int            cycle_cnt = 0;
	logic          hold_req = 1'b0;
	logic          hold_done = 1'b0;
	int            hold_cnt = 0;
	int            stall_pct = 0;
	int            pat_left = 0;

	pixel_blend_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.src_pixel   (src_pixel),
		.dst_pixel   (dst_pixel),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pixel   (out_pixel),
		.write_enable(write_enable)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words still pending", cycle_cnt,
				pending_pixels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic blend_result_t blend_pixel(blend_mode_t mode, logic [7:0] ga,
			logic [31:0] src, logic [31:0] dst);
		blend_result_t res;
		int unsigned   w, g, a, s, d, t, fw;
		int            i;
		res.pix = dst;
		res.we = 1'b0;
		fw = 32'(FULL_WEIGHT);
		if (mode == MODE_COPY) begin
			res.pix = src;
			res.we = 1'b1;
		end else if (ga != 8'd0) begin
			g = 32'(ga);
			a = 32'(src[31:24]);
			w = g * a;
			res.pix[31:24] = CHAN_MAX;
			res.we = 1'b1;
			for (i = 0; i < 3; i++) begin
				s = 32'(src[8*i +: 8]);
				d = 32'(dst[8*i +: 8]);
				case (mode)
					MODE_BLEND: t = (w * s + (fw - w) * d) / fw;
					MODE_ADD: begin
						t = w * s / fw + d;
						if (t > 32'(CHAN_MAX))
							t = 32'(CHAN_MAX);
					end
					default: begin
						t = w * s / fw;
						t = (t > d) ? 0 : d - t;
					end
				endcase
				res.pix[8*i +: 8] = t[7:0];
			end
		end
		return res;
	endfunction

	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		int          i;
		for (i = 0; i < 4; i++) begin
			case ($urandom_range(0, 9))
				0: p[8*i +: 8] = 8'h00;
				1: p[8*i +: 8] = 8'hFF;
				default: p[8*i +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return p;
	endfunction

	task automatic send_word(logic [31:0] src, logic [31:0] dst, bit known,
			blend_result_t typed);
		blend_result_t want;
		in_valid <= 1'b1;
		src_pixel <= src;
		dst_pixel <= dst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = known ? typed : blend_pixel(cur_mode, cur_ga, src, dst);
		pending_pixels.push_back(want);
		mode_words[cur_mode]++;
		if (!want.we)
			n_suppressed++;
	endtask

	task automatic idle_input(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the pipeline empty
	task automatic apply_config(logic [7:0] mode_data, logic [7:0] ga);
		if (mode_data != cur_mode_data || ga != cur_ga) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (pending_pixels.size() != 0)
				@(posedge clk);
			repeat (8) @(posedge clk);
			if (mode_data != cur_mode_data) begin
				write_reg(REG_BLEND_MODE, mode_data);
				cur_mode_data = mode_data;
				cur_mode = blend_mode_t'(mode_data[1:0]);
			end
			if (ga != cur_ga) begin
				write_reg(REG_GLOBAL_ALPHA, ga);
				cur_ga = ga;
			end
		end
	endtask

	task automatic random_bursts(int count);
		int left, burst, k;
		left = count;
		while (left > 0) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			if (burst > left)
				burst = left;
			for (k = 0; k < burst; k++)
				send_word(rand_pixel(), rand_pixel(), 1'b0, '0);
			left -= burst;
			n_random += burst;
			if ($urandom_range(0, 2) != 0)
				idle_input($urandom_range(1, 6));
		end
	endtask

	// receiver: one long hold-off on request, otherwise stall odds that change now and then
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_cnt <= hold_cnt + 1;
			out_stall <= (hold_cnt < HOLD_CYCLES);
			if (hold_cnt >= HOLD_CYCLES)
				hold_done <= 1'b1;
		end else begin
			if (pat_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct <= 0;
					1: stall_pct <= 25;
					2: stall_pct <= 60;
					default: stall_pct <= 90;
				endcase
				pat_left <= $urandom_range(20, 200);
			end else begin
				pat_left <= pat_left - 1;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		blend_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("out word with nothing pending: out_pixel %h write_enable %b",
					out_pixel, write_enable);
				n_errors++;
			end else begin
				want = pending_pixels.pop_front();
				n_checked++;
				if (out_pixel !== want.pix) begin
					$error("out_pixel: expected %h, got %h", want.pix, out_pixel);
					n_errors++;
				end
				if (write_enable !== want.we) begin
					$error("write_enable: expected %b, got %b", want.we, write_enable);
					n_errors++;
				end
			end
		end
	end

	initial begin
		blend_row_t    row;
		blend_result_t typed;
		logic [7:0]    ga;
		int            phase;
		int            k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++) begin
			row = DIRECTED[k];
			apply_config(row.mode_data, row.ga);
			typed.pix = row.exp_pix;
			typed.we = row.exp_we;
			send_word(row.src, row.dst, row.known, typed);
		end

		// fill the pipeline against a receiver that holds off
		apply_config(8'h01, 8'hB4);
		hold_req <= 1'b1;
		for (k = 0; k < 60; k++)
			send_word(rand_pixel(), rand_pixel(), 1'b0, '0);
		n_random += 60;

		phase = 0;
		while (n_random < RANDOM_WORDS) begin
			case ($urandom_range(0, 5))
				0: ga = 8'h00;
				1: ga = 8'hFF;
				2: ga = 8'h01;
				default: ga = 8'($urandom_range(0, 255));
			endcase
			apply_config({6'($urandom_range(0, 63)), 2'(phase % 4)}, ga);
			random_bursts($urandom_range(60, 200));
			phase++;
		end

		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("checked %0d words (copy %0d, blend %0d, add %0d, subtract %0d)",
			n_checked, mode_words[MODE_COPY], mode_words[MODE_BLEND],
			mode_words[MODE_ADD], mode_words[MODE_SUB]);
		$display("%0d suppressed writes, %0d config phases, %0d mismatches",
			n_suppressed, phase, n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
